// File: hdl/epf_pkg.sv
// ----------------------------------------------------------------------------
// epf_pkg: shared types and functions of the escaped packet framer
// Register indexes, code set, frame record, CRC-16 and byte stuffing helpers.
// ----------------------------------------------------------------------------
package epf_pkg;

  localparam logic [15:0] CrcPoly    = 16'h1021;
  localparam int unsigned MaxLine    = 8;
  localparam int unsigned LineIdxW   = $clog2(MaxLine);
  localparam int unsigned LineCntW   = LineIdxW + 1;
  localparam int unsigned CfgAddrW   = 3;

  typedef enum logic [CfgAddrW-1:0] {
    REG_START_CODE  = 3'd0,
    REG_END_CODE    = 3'd1,
    REG_ESCAPE_CODE = 3'd2,
    REG_START_SUB   = 3'd3,
    REG_END_SUB     = 3'd4,
    REG_ESCAPE_SUB  = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [7:0] start_code;
    logic [7:0] end_code;
    logic [7:0] escape_code;
    logic [7:0] start_substitute;
    logic [7:0] end_substitute;
    logic [7:0] escape_substitute;
  } codes_t;

  typedef struct packed {
    logic       esc;
    logic [7:0] val;
  } stuff_t;

  typedef struct packed {
    logic [MaxLine-1:0][7:0] bytes;
    logic [LineIdxW-1:0]     last_idx;
  } frame_t;

  function automatic logic [15:0] crc_update(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  function automatic stuff_t stuff_byte(logic [7:0] b, codes_t codes);
    stuff_t s;
    s.esc = 1'b1;
    if (b == codes.start_code) begin
      s.val = codes.start_substitute;
    end else if (b == codes.end_code) begin
      s.val = codes.end_substitute;
    end else if (b == codes.escape_code) begin
      s.val = codes.escape_substitute;
    end else begin
      s.esc = 1'b0;
      s.val = b;
    end
    return s;
  endfunction

endpackage

// File: hdl/escaped_packet_framer_crc16_unit.sv
// ----------------------------------------------------------------------------
// escaped_packet_framer_crc16_unit: byte stuffing packet framer, CRC-16 trailer
// Datapath: a payload byte is held in the input register and, when the sequencer
// is free, loaded into the result register, from which its first line byte is offered.
// Throughput: one line byte per cycle while the receiver is ready; an item causes
// 1 to 8 line bytes at the output sequencer.
// A new payload byte is taken while the previous list is still going out.
// Reset: codes, CRC and packet state cleared; no clearing pass.
// ----------------------------------------------------------------------------
module escaped_packet_framer_crc16_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [epf_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [7:0]                   cfg_wdata_i,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,   // [7:0] payload_byte
  input  logic                         s_axis_tlast,   // final_byte
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [7:0]                   m_axis_tdata,   // [7:0] line_byte
  output logic                         m_axis_tlast    // run_end
);

  epf_pkg::codes_t codes_q;
  logic            in_valid_q;
  logic [7:0]      in_byte_q;
  logic            in_last_q;
  logic [15:0]     crc_q, crc_d;
  logic            inside_q, inside_d;
  epf_pkg::frame_t frame;
  logic            emit_free;
  logic            load;
  logic            accept;

  assign load          = in_valid_q & emit_free;
  assign s_axis_tready = ~in_valid_q | load;
  assign accept        = s_axis_tvalid & s_axis_tready;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      codes_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        epf_pkg::REG_START_CODE:  codes_q.start_code        <= cfg_wdata_i;
        epf_pkg::REG_END_CODE:    codes_q.end_code          <= cfg_wdata_i;
        epf_pkg::REG_ESCAPE_CODE: codes_q.escape_code       <= cfg_wdata_i;
        epf_pkg::REG_START_SUB:   codes_q.start_substitute  <= cfg_wdata_i;
        epf_pkg::REG_END_SUB:     codes_q.end_substitute    <= cfg_wdata_i;
        epf_pkg::REG_ESCAPE_SUB:  codes_q.escape_substitute <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // input register and packet state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      crc_q      <= '0;
      inside_q   <= 1'b0;
    end else begin
      if (accept) begin
        in_valid_q <= 1'b1;
      end else if (load) begin
        in_valid_q <= 1'b0;
      end
      if (load) begin
        crc_q    <= crc_d;
        inside_q <= inside_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  epf_frame_build u_build (
    .byte_i   (in_byte_q),
    .last_i   (in_last_q),
    .crc_i    (crc_q),
    .inside_i (inside_q),
    .codes_i  (codes_q),
    .frame_o  (frame),
    .crc_o    (crc_d),
    .inside_o (inside_d)
  );

  epf_emitter u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (load),
    .frame_i       (frame),
    .free_o        (emit_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// File: hdl/epf_frame_build.sv
// ----------------------------------------------------------------------------
// epf_frame_build: line byte list for one payload byte
// Prepends the start code on the first byte of a packet, stuffs the byte and, on
// the last byte, appends the stuffed checksum and the end code; advances the running CRC.
// ----------------------------------------------------------------------------
module epf_frame_build (
  input  logic [7:0]      byte_i,
  input  logic            last_i,
  input  logic [15:0]     crc_i,
  input  logic            inside_i,
  input  epf_pkg::codes_t codes_i,
  output epf_pkg::frame_t frame_o,
  output logic [15:0]     crc_o,
  output logic            inside_o
);

  logic [15:0]                      crc_run;
  logic [15:0]                      crc_upd;
  logic [2:0][7:0]                  src;
  logic [epf_pkg::LineCntW-1:0]     pos;
  logic [epf_pkg::LineCntW-1:0]     pos_m1;
  epf_pkg::stuff_t                  st;

  assign crc_run = inside_i ? crc_i : 16'h0000;
  assign crc_upd = epf_pkg::crc_update(crc_run, byte_i);
  assign crc_o   = last_i ? 16'h0000 : crc_upd;
  assign inside_o = ~last_i;

  always_comb begin
    frame_o.bytes = '0;
    pos           = '0;
    st            = '0;
    src[0]        = byte_i;
    src[1]        = crc_upd[7:0];
    src[2]        = crc_upd[15:8];
    if (!inside_i) begin
      frame_o.bytes[pos[epf_pkg::LineIdxW-1:0]] = codes_i.start_code;
      pos = pos + 1'b1;
    end
    for (int k = 0; k < 3; k++) begin
      if (k == 0 || last_i) begin
        st = epf_pkg::stuff_byte(src[k], codes_i);
        if (st.esc) begin
          frame_o.bytes[pos[epf_pkg::LineIdxW-1:0]] = codes_i.escape_code;
          pos = pos + 1'b1;
        end
        frame_o.bytes[pos[epf_pkg::LineIdxW-1:0]] = st.val;
        pos = pos + 1'b1;
      end
    end
    if (last_i) begin
      frame_o.bytes[pos[epf_pkg::LineIdxW-1:0]] = codes_i.end_code;
      pos = pos + 1'b1;
    end
    pos_m1           = pos - 1'b1;
    frame_o.last_idx = pos_m1[epf_pkg::LineIdxW-1:0];
  end

endmodule

// File: hdl/epf_emitter.sv
// ----------------------------------------------------------------------------
// epf_emitter: result register and line byte sequencer
// Holds one byte list and puts it out one byte per transfer, tlast on the
// final byte of the list.
// ----------------------------------------------------------------------------
module epf_emitter (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  epf_pkg::frame_t frame_i,
  output logic            free_o,
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // [7:0] line_byte
  output logic            m_axis_tlast    // run_end
);

  logic                          valid_q, valid_d;
  logic [epf_pkg::LineIdxW-1:0]  idx_q, idx_d;
  epf_pkg::frame_t               frame_q;
  logic                          at_last;
  logic                          xfer;

  assign at_last       = (idx_q == frame_q.last_idx);
  assign xfer          = valid_q & m_axis_tready;
  assign free_o        = ~valid_q | (xfer & at_last);
  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = frame_q.bytes[idx_q];
  assign m_axis_tlast  = at_last;

  always_comb begin
    valid_d = valid_q;
    idx_d   = idx_q;
    if (load_i) begin
      valid_d = 1'b1;
      idx_d   = '0;
    end else if (xfer) begin
      if (at_last) begin
        valid_d = 1'b0;
      end else begin
        idx_d = idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      frame_q <= frame_i;
    end
  end

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for escaped_packet_framer_crc16_unit
// Drives payload bytes over the input stream under several code sets and
// handshake patterns. A scoreboard predicts the stuffed line bytes, the
// framing codes and the CRC-16 trailer of each transfer, and compares them
// in order with what leaves the output stream.
// ----------------------------------------------------------------------------
module testbench;

  localparam logic [epf_pkg::CfgAddrW-1:0] RegSpareA = 3'd6;
  localparam logic [epf_pkg::CfgAddrW-1:0] RegSpareB = 3'd7;
  localparam int unsigned QuietLimit = 4000;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned RandPhases = 8;
  localparam int unsigned PhaseItems = 39;

  typedef struct packed {
    logic [7:0] line;
    logic       run_end;
  } line_rec_t;

  class frame_scoreboard;
    epf_pkg::codes_t codes = '0;
    logic [15:0]     crc = 16'h0000;
    bit              pkt_open;
    line_rec_t       line_q[$];
    int              errors;

    function void set_code(logic [epf_pkg::CfgAddrW-1:0] addr, logic [7:0] v);
      case (addr)
        epf_pkg::REG_START_CODE:  codes.start_code = v;
        epf_pkg::REG_END_CODE:    codes.end_code = v;
        epf_pkg::REG_ESCAPE_CODE: codes.escape_code = v;
        epf_pkg::REG_START_SUB:   codes.start_substitute = v;
        epf_pkg::REG_END_SUB:     codes.end_substitute = v;
        epf_pkg::REG_ESCAPE_SUB:  codes.escape_substitute = v;
        default: ;
      endcase
    endfunction

    function void push_line(logic [7:0] b);
      line_rec_t r;
      r.line = b;
      r.run_end = 1'b0;
      line_q.push_back(r);
    endfunction

    function void push_escaped(logic [7:0] b);
      if (b == codes.start_code) begin
        push_line(codes.escape_code);
        push_line(codes.start_substitute);
      end else if (b == codes.end_code) begin
        push_line(codes.escape_code);
        push_line(codes.end_substitute);
      end else if (b == codes.escape_code) begin
        push_line(codes.escape_code);
        push_line(codes.escape_substitute);
      end else begin
        push_line(b);
      end
    endfunction

    function void note_payload(logic [7:0] b, logic last);
      logic fb;
      if (!pkt_open) begin
        push_line(codes.start_code);
        crc = 16'h0000;
        pkt_open = 1'b1;
      end
      for (int i = 7; i >= 0; i--) begin
        fb = crc[15] ^ b[i];
        crc = {crc[14:0], 1'b0} ^ (fb ? epf_pkg::CrcPoly : 16'h0000);
      end
      push_escaped(b);
      if (last) begin
        push_escaped(crc[7:0]);
        push_escaped(crc[15:8]);
        push_line(codes.end_code);
        crc = 16'h0000;
        pkt_open = 1'b0;
      end
      line_q[line_q.size()-1].run_end = 1'b1;
    endfunction

    function void check_line(logic [7:0] b, logic last);
      line_rec_t exp_rec;
      if (line_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected line byte %02h run_end %0b", b, last);
        return;
      end
      exp_rec = line_q.pop_front();
      if (exp_rec.line !== b || exp_rec.run_end !== last) begin
        errors++;
        if (errors <= 10) begin
          $display("line byte mismatch: expected %02h run_end %0b, got %02h run_end %0b",
                   exp_rec.line, exp_rec.run_end, b, last);
        end
      end
    endfunction
  endclass

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         cfg_we_i;
  logic [epf_pkg::CfgAddrW-1:0] cfg_addr_i;
  logic [7:0]                   cfg_wdata_i;
  logic                         s_axis_tvalid;
  logic                         s_axis_tready;
  logic [7:0]                   s_axis_tdata;   // [7:0] payload_byte
  logic                         s_axis_tlast;   // final_byte
  logic                         m_axis_tvalid;
  logic                         m_axis_tready;
  logic [7:0]                   m_axis_tdata;   // [7:0] line_byte
  logic                         m_axis_tlast;   // run_end

  frame_scoreboard sb = new;
  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned hold_left;
  int unsigned quiet_cycles;

  escaped_packet_framer_crc16_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // receiver: random stalls, or a counted hold-off when requested
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_line(m_axis_tdata, m_axis_tlast);
      end
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QuietLimit) begin
        $display("watchdog expired, no transfer for %0d cycles", quiet_cycles);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [epf_pkg::CfgAddrW-1:0] addr,
                           input logic [7:0] data);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    sb.set_code(addr, data);
  endtask

  task automatic load_codes(input epf_pkg::codes_t c);
    write_reg(epf_pkg::REG_START_CODE, c.start_code);
    write_reg(epf_pkg::REG_END_CODE, c.end_code);
    write_reg(epf_pkg::REG_ESCAPE_CODE, c.escape_code);
    write_reg(epf_pkg::REG_START_SUB, c.start_substitute);
    write_reg(epf_pkg::REG_END_SUB, c.end_substitute);
    write_reg(epf_pkg::REG_ESCAPE_SUB, c.escape_substitute);
    write_reg($urandom_range(1) ? RegSpareA : RegSpareB, 8'($urandom_range(255)));
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic send_payload(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_payload(b, last);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (sb.line_q.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  function automatic epf_pkg::codes_t make_codes(int unsigned style);
    epf_pkg::codes_t c;
    c = epf_pkg::codes_t'({$urandom, $urandom});
    case (style)
      1: begin
        c.start_code = 8'hFF;
        c.end_code = 8'hFF;
        c.escape_code = 8'hFF;
        c.start_substitute = 8'h00;
        c.end_substitute = 8'h00;
        c.escape_substitute = 8'h00;
      end
      2: begin
        c.start_code = 8'h00;
        c.end_code = 8'h01;
        c.escape_code = 8'h02;
        c.start_substitute = 8'hFF;
        c.end_substitute = 8'hFE;
        c.escape_substitute = 8'hFD;
      end
      3: begin
        c.end_code = c.start_code;
      end
      default: ;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] pick_payload();
    case ($urandom_range(9))
      0: return sb.codes.start_code;
      1: return sb.codes.end_code;
      2: return sb.codes.escape_code;
      3: return sb.codes.start_substitute ^ 8'($urandom_range(1));
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  initial begin
    epf_pkg::codes_t c;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_addr_i    = epf_pkg::REG_START_CODE;
    cfg_wdata_i   = 8'h00;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'h00;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b0;
    idle_pct      = 0;
    stall_pct     = 0;
    hold_left     = 0;
    quiet_cycles  = 0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // all codes zero after reset
    send_payload(8'h00, 1'b1);
    send_payload(8'hFF, 1'b0);
    send_payload(8'h00, 1'b0);
    send_payload(8'h01, 1'b1);
    wait_drained();

    c.start_code = 8'hC0;
    c.end_code = 8'hC1;
    c.escape_code = 8'hDB;
    c.start_substitute = 8'hDC;
    c.end_substitute = 8'hDD;
    c.escape_substitute = 8'hDE;
    load_codes(c);
    send_payload(8'hC0, 1'b0);
    send_payload(8'hC1, 1'b0);
    send_payload(8'hDB, 1'b0);
    send_payload(8'hDC, 1'b0);
    send_payload(8'hDD, 1'b0);
    send_payload(8'hDE, 1'b0);
    send_payload(8'h00, 1'b0);
    send_payload(8'hFF, 1'b1);
    send_payload(8'hC0, 1'b1);
    send_payload(8'hDB, 1'b1);
    send_payload(8'h5A, 1'b0);
    wait_drained();

    // coinciding codes, packet left open across the write
    c.start_code = 8'hAA;
    c.end_code = 8'hAA;
    c.escape_code = 8'hAA;
    c.start_substitute = 8'h01;
    c.end_substitute = 8'h02;
    c.escape_substitute = 8'h03;
    load_codes(c);
    send_payload(8'hAA, 1'b1);
    send_payload(8'h55, 1'b1);
    wait_drained();
    c.start_code = 8'h10;
    c.end_code = 8'h20;
    c.escape_code = 8'h10;
    load_codes(c);
    send_payload(8'h10, 1'b0);
    send_payload(8'h20, 1'b0);
    send_payload(8'h03, 1'b1);
    wait_drained();

    for (int unsigned ph = 0; ph < RandPhases; ph++) begin
      load_codes(make_codes(ph % 4));
      case ((ph / 2) % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 86; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 86; end
        default: begin idle_pct = 19; stall_pct = 19; end
      endcase
      for (int unsigned n = 0; n < PhaseItems; n++) begin
        if (ph == 1 && n == 10) hold_left = HoldOffCycles;
        if (ph == 4 && n == 20) begin
          s_axis_tvalid <= 1'b0;
          @(negedge clk_i);
          while (sb.line_q.size() != 0) @(negedge clk_i);
        end
        send_payload(pick_payload(), ($urandom_range(4) == 0));
      end
      wait_drained();
    end

    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
